// ----- src/llp_pkg.sv -----
package llp_pkg;

  // Grammar and stack sizes.
  localparam int NONTERMINALS   = 16;
  localparam int TERMINALS      = 32;
  localparam int MAX_RHS        = 4;
  localparam int STACK_DEPTH    = 64;
  localparam int MAX_EXPANSIONS = 32;

  // Derived widths.
  localparam int NT_W       = $clog2(NONTERMINALS);
  localparam int TE_W       = $clog2(TERMINALS);
  localparam int TBL_AW     = NT_W + TE_W;
  localparam int TABLE_SIZE = NONTERMINALS * TERMINALS;
  localparam int SA_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int EXP_W      = $clog2(MAX_EXPANSIONS + 1);
  localparam int PUSH_W     = $clog2(MAX_RHS + 1);

  // Fixed field widths.
  localparam int SYM_W   = 6;
  localparam int LEN_W   = 3;
  localparam int NUM_SYM = 4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TOKEN = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ACT_EXPAND      = 3'd0,
    ACT_MATCH       = 3'd1,
    ACT_ACCEPT      = 3'd2,
    ACT_NO_RULE     = 3'd3,
    ACT_OVERFLOW    = 3'd4,
    ACT_STEP_LIMIT  = 3'd5,
    ACT_NOT_PARSING = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_TOP,
    ST_EVAL,
    ST_LOOK,
    ST_PUSH,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] entry_nonterminal;
    logic [4:0] entry_terminal;
    logic [7:0] rule_number;
    logic [2:0] rhs_length;
    logic [5:0] rhs_sym0;
    logic [5:0] rhs_sym1;
    logic [5:0] rhs_sym2;
    logic [5:0] rhs_sym3;
    logic [4:0] token;
  } cmd_t;

  typedef struct packed {
    act_t       action;
    logic [5:0] symbol;
    logic [7:0] rule_used;
    logic       last;
  } res_t;

  typedef struct packed {
    logic                            valid;
    logic [7:0]                      rule;
    logic [LEN_W-1:0]                len;
    logic [NUM_SYM-1:0][SYM_W-1:0]   sym;
  } tbl_entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    tbl_entry_t        wdata;
    logic              re;
    logic [TBL_AW-1:0] raddr;
  } tbl_port_t;

  typedef struct packed {
    logic             we;
    logic [SA_W-1:0]  waddr;
    logic [SYM_W-1:0] wdata;
    logic             re;
    logic [SA_W-1:0]  raddr;
  } stk_port_t;

  typedef struct packed {
    state_t           state;
    logic [CNT_W-1:0] stack_count;
    logic             active;
  } status_t;

endpackage

// ----- src/llp_rule_table.sv -----
module llp_rule_table (
  input  logic                clk,
  input  llp_pkg::tbl_port_t  port,
  output llp_pkg::tbl_entry_t rdata
);

  llp_pkg::tbl_entry_t mem [llp_pkg::TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    if (port.re) begin
      rdata <= mem[port.raddr];
    end
  end

endmodule

// ----- src/llp_sym_stack.sv -----
module llp_sym_stack (
  input  logic                             clk,
  input  llp_pkg::stk_port_t               port,
  output logic [llp_pkg::SYM_W-1:0]        rdata
);

  logic [llp_pkg::SYM_W-1:0] mem [llp_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    if (port.re) begin
      rdata <= mem[port.raddr];
    end
  end

endmodule

// ----- src/llp_ctrl.sv -----
module llp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [3:0]                 start_nt,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  llp_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_stall,
  output llp_pkg::res_t              res,
  output llp_pkg::tbl_port_t         tbl,
  input  llp_pkg::tbl_entry_t        tbl_rdata,
  output llp_pkg::stk_port_t         stk,
  input  logic [llp_pkg::SYM_W-1:0]  stk_rdata,
  output llp_pkg::status_t           status
);

  llp_pkg::state_t                  state, state_next;
  logic [llp_pkg::TBL_AW-1:0]       clr_addr, clr_addr_next;
  logic [llp_pkg::CNT_W-1:0]        stack_count, stack_count_next;
  logic                             active, active_next;
  logic [4:0]                       token, token_next;
  logic [llp_pkg::EXP_W-1:0]        exp_cnt, exp_cnt_next;
  logic [llp_pkg::PUSH_W-1:0]       push_cnt, push_cnt_next;
  logic                             res_valid_next;
  llp_pkg::res_t                    res_next;

  logic                             can_emit;
  logic                             emit;
  llp_pkg::res_t                    emit_data;
  logic [llp_pkg::LEN_W-1:0]        len_sat;
  logic [llp_pkg::CNT_W:0]          depth_sum;
  logic [1:0]                       sym_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= llp_pkg::ST_CLEAR;
      clr_addr    <= '0;
      stack_count <= '0;
      active      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      stack_count <= stack_count_next;
      active      <= active_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    token    <= token_next;
    exp_cnt  <= exp_cnt_next;
    push_cnt <= push_cnt_next;
    res      <= res_next;
  end

  assign can_emit = !res_valid || !res_stall;
  assign cmd_stall = (state != llp_pkg::ST_IDLE);
  assign status = '{state: state, stack_count: stack_count, active: active};

  // Stack depth after replacing the top with the looked-up right-hand side.
  assign depth_sum = {1'b0, stack_count} + {{(llp_pkg::CNT_W + 1 - llp_pkg::LEN_W){1'b0}},
                     tbl_rdata.len} - 1'b1;
  assign sym_idx = 2'(push_cnt - 1'b1);
  assign len_sat = (cmd.rhs_length > llp_pkg::LEN_W'(llp_pkg::MAX_RHS)) ?
                   llp_pkg::LEN_W'(llp_pkg::MAX_RHS) : cmd.rhs_length;

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    stack_count_next = stack_count;
    active_next      = active;
    token_next       = token;
    exp_cnt_next     = exp_cnt;
    push_cnt_next    = push_cnt;
    tbl              = '0;
    stk              = '0;
    emit             = 1'b0;
    emit_data        = '{action: llp_pkg::ACT_NO_RULE, symbol: stk_rdata,
                         rule_used: 8'd0, last: 1'b1};

    case (state)
      llp_pkg::ST_CLEAR: begin
        tbl.we        = 1'b1;
        tbl.waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == llp_pkg::TBL_AW'(llp_pkg::TABLE_SIZE - 1)) begin
          state_next = llp_pkg::ST_IDLE;
        end
      end

      llp_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            llp_pkg::OP_WRITE: begin
              if (int'(cmd.entry_nonterminal) < llp_pkg::NONTERMINALS &&
                  int'(cmd.entry_terminal) < llp_pkg::TERMINALS) begin
                tbl.we          = 1'b1;
                tbl.waddr       = {cmd.entry_nonterminal[llp_pkg::NT_W-1:0],
                                   cmd.entry_terminal[llp_pkg::TE_W-1:0]};
                tbl.wdata.valid = 1'b1;
                tbl.wdata.rule  = cmd.rule_number;
                tbl.wdata.len   = len_sat;
                tbl.wdata.sym   = {cmd.rhs_sym3, cmd.rhs_sym2, cmd.rhs_sym1, cmd.rhs_sym0};
              end
            end
            llp_pkg::OP_START: begin
              // The end marker goes to the bottom now, the start symbol next cycle.
              stk.we           = 1'b1;
              stk.waddr        = '0;
              stk.wdata        = '0;
              stack_count_next = llp_pkg::CNT_W'(2);
              active_next      = 1'b1;
              state_next       = llp_pkg::ST_START;
            end
            llp_pkg::OP_TOKEN: begin
              token_next   = cmd.token;
              exp_cnt_next = '0;
              state_next   = llp_pkg::ST_TOP;
            end
            default: begin
            end
          endcase
        end
      end

      llp_pkg::ST_START: begin
        stk.we     = 1'b1;
        stk.waddr  = llp_pkg::SA_W'(1);
        stk.wdata  = {2'b10, start_nt};
        state_next = llp_pkg::ST_IDLE;
      end

      llp_pkg::ST_TOP: begin
        if (!active || stack_count == '0) begin
          emit_data = '{action: llp_pkg::ACT_NOT_PARSING, symbol: 6'd0,
                        rule_used: 8'd0, last: 1'b1};
          if (can_emit) begin
            emit             = 1'b1;
            active_next      = 1'b0;
            stack_count_next = '0;
            state_next       = llp_pkg::ST_IDLE;
          end
        end else begin
          stk.re     = 1'b1;
          stk.raddr  = llp_pkg::SA_W'(stack_count - 1'b1);
          state_next = llp_pkg::ST_EVAL;
        end
      end

      llp_pkg::ST_EVAL: begin
        if (!stk_rdata[5]) begin
          // Terminal on top: match, accept or mismatch ends this token.
          if (can_emit) begin
            emit       = 1'b1;
            state_next = llp_pkg::ST_IDLE;
            if (stk_rdata == {1'b0, token}) begin
              stack_count_next = stack_count - 1'b1;
              if (token == 5'd0) begin
                emit_data.action = llp_pkg::ACT_ACCEPT;
                active_next      = 1'b0;
                stack_count_next = '0;
              end else begin
                emit_data.action = llp_pkg::ACT_MATCH;
                if (stack_count == llp_pkg::CNT_W'(1)) begin
                  active_next = 1'b0;
                end
              end
            end else begin
              active_next      = 1'b0;
              stack_count_next = '0;
            end
          end
        end else if (exp_cnt >= llp_pkg::EXP_W'(llp_pkg::MAX_EXPANSIONS)) begin
          emit_data.action = llp_pkg::ACT_STEP_LIMIT;
          if (can_emit) begin
            emit             = 1'b1;
            active_next      = 1'b0;
            stack_count_next = '0;
            state_next       = llp_pkg::ST_IDLE;
          end
        end else if (int'(stk_rdata[4:0]) >= llp_pkg::NONTERMINALS ||
                     int'(token) >= llp_pkg::TERMINALS) begin
          if (can_emit) begin
            emit             = 1'b1;
            active_next      = 1'b0;
            stack_count_next = '0;
            state_next       = llp_pkg::ST_IDLE;
          end
        end else begin
          tbl.re     = 1'b1;
          tbl.raddr  = {stk_rdata[llp_pkg::NT_W-1:0], token[llp_pkg::TE_W-1:0]};
          state_next = llp_pkg::ST_LOOK;
        end
      end

      llp_pkg::ST_LOOK: begin
        if (!tbl_rdata.valid) begin
          if (can_emit) begin
            emit             = 1'b1;
            active_next      = 1'b0;
            stack_count_next = '0;
            state_next       = llp_pkg::ST_IDLE;
          end
        end else if (depth_sum > (llp_pkg::CNT_W + 1)'(llp_pkg::STACK_DEPTH)) begin
          emit_data.action = llp_pkg::ACT_OVERFLOW;
          if (can_emit) begin
            emit             = 1'b1;
            active_next      = 1'b0;
            stack_count_next = '0;
            state_next       = llp_pkg::ST_IDLE;
          end
        end else begin
          emit_data = '{action: llp_pkg::ACT_EXPAND, symbol: stk_rdata,
                        rule_used: tbl_rdata.rule, last: 1'b0};
          if (can_emit) begin
            emit             = 1'b1;
            stack_count_next = stack_count - 1'b1;
            push_cnt_next    = llp_pkg::PUSH_W'(tbl_rdata.len);
            exp_cnt_next     = exp_cnt + 1'b1;
            if (tbl_rdata.len != '0) begin
              state_next = llp_pkg::ST_PUSH;
            end else if (stack_count == llp_pkg::CNT_W'(1)) begin
              state_next = llp_pkg::ST_EMPTY;
            end else begin
              state_next = llp_pkg::ST_TOP;
            end
          end
        end
      end

      llp_pkg::ST_PUSH: begin
        // Rightmost symbol first so that the leftmost ends on top.
        stk.we           = 1'b1;
        stk.waddr        = stack_count[llp_pkg::SA_W-1:0];
        stk.wdata        = tbl_rdata.sym[sym_idx];
        stack_count_next = stack_count + 1'b1;
        push_cnt_next    = push_cnt - 1'b1;
        if (push_cnt == llp_pkg::PUSH_W'(1)) begin
          state_next = llp_pkg::ST_TOP;
        end
      end

      llp_pkg::ST_EMPTY: begin
        emit_data.symbol = 6'd0;
        if (can_emit) begin
          emit             = 1'b1;
          active_next      = 1'b0;
          stack_count_next = '0;
          state_next       = llp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = llp_pkg::ST_IDLE;
      end
    endcase

    res_valid_next = res_valid && res_stall;
    res_next       = res;
    if (emit) begin
      res_valid_next = 1'b1;
      res_next       = emit_data;
    end
  end

endmodule

// ----- src/ll1_predictive_parser.sv -----
// Channel | Direction | Handshake            | Payload
// cmd     | in        | cmd_valid, cmd_stall | llp_pkg::cmd_t (op, table entry, token)
// res     | out       | res_valid, res_stall | llp_pkg::res_t (action, symbol, rule, last)
// apb     | in/out    | psel, penable, pready| start_nonterminal at byte address 0
//
// A table write is done in the idle state; a parse start writes the end marker, then the start symbol.
// A token reads the stack top, then evaluates it and, for a nonterminal, looks up the table; with no
// parse open it emits at once. An expansion then pushes its right-hand symbols, one push per cycle,
// and a new command is taken only once the sequencer is back in idle.
// After reset all 512 entries of the rule table are swept clear before the first item.
// A held result stalls the sequencer only when it has the next result to emit.
module ll1_predictive_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  llp_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output llp_pkg::res_t res
);

  // Register index of start_nonterminal in the configuration space.
  localparam logic REG_START_NT = 1'b0;

  logic [3:0]                start_nt;
  llp_pkg::tbl_port_t        tbl;
  llp_pkg::tbl_entry_t       tbl_rdata;
  llp_pkg::stk_port_t        stk;
  logic [llp_pkg::SYM_W-1:0] stk_rdata;
  llp_pkg::status_t          status;

  // The configuration port is always ready; a write lands in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_nt <= 4'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_START_NT) begin
      start_nt <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_START_NT) begin
      prdata = {28'd0, start_nt};
    end
  end

  // Sequencer: owns the stack count, the token loop and the result register.
  llp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start_nt  (start_nt),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .tbl       (tbl),
    .tbl_rdata (tbl_rdata),
    .stk       (stk),
    .stk_rdata (stk_rdata),
    .status    (status)
  );

  // Parse table: one entry per (nonterminal, terminal), valid bit included.
  llp_rule_table u_rule_table (
    .clk   (clk),
    .port  (tbl),
    .rdata (tbl_rdata)
  );

  // Symbol stack; the count lives in the sequencer.
  llp_sym_stack u_sym_stack (
    .clk   (clk),
    .port  (stk),
    .rdata (stk_rdata)
  );

  // The stack never holds more than its depth.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    int'(status.stack_count) <= llp_pkg::STACK_DEPTH)
    else $error("stack count beyond depth");

  // Only an expand leaves more results to come for the same token.
  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.action == llp_pkg::ACT_EXPAND) != res.last))
    else $error("last flag disagrees with action");

  // A token puts the sequencer to work, so the next item waits.
  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.op == llp_pkg::OP_TOKEN) |=> cmd_stall)
    else $error("token accepted without busy");

  // A parse that has ended leaves an empty stack.
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(status.active) |-> (status.stack_count == '0))
    else $error("stack left non-empty after parse end");

endmodule
